// File: sv/pqu_pkg.sv
package pqu_pkg;

	// queue depth and derived widths
	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// payload widths
	localparam int ID_W    = 32;
	localparam int PRIO_W  = 16;
	localparam int STAMP_W = 31;
	localparam int OSTAMP_W = 32;

	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

	// result status codes
	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_POPPED   = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// operation codes
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_POP    = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // item accepted: capture fields and compare results
		logic apply;  // update the queue and load the result register
	} cmd_t;

endpackage

// File: sv/pqu_if.sv
interface pqu_req_if;
	logic                valid;
	logic                ready;
	logic                func;
	logic signed [31:0]  new_id;
	logic signed [15:0]  new_priority;

	modport source (output valid, output func, output new_id, output new_priority, input ready);
	modport sink   (input valid, input func, input new_id, input new_priority, output ready);
endinterface

interface pqu_rsp_if;
	logic                valid;
	logic                ready;
	logic [2:0]          status;
	logic signed [31:0]  out_id;
	logic signed [15:0]  out_priority;
	logic signed [31:0]  out_stamp;

	modport source (output valid, output status, output out_id, output out_priority,
		output out_stamp, input ready);
	modport sink   (input valid, input status, input out_id, input out_priority,
		input out_stamp, output ready);
endinterface

// File: sv/pqu_ctrl.sv
module pqu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output pqu_pkg::cmd_t cmd
);
	import pqu_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_APPLY = 2'b10
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   apply_go;

	// apply waits only while an older result is still unclaimed
	assign apply_go  = (state_q == S_APPLY) && (!rsp_valid_q || rsp_ready);
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	assign cmd.load  = req_valid && req_ready;
	assign cmd.apply = apply_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (apply_go) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (apply_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/pqu_dp.sv
module pqu_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pqu_pkg::cmd_t                  cmd,
	input  logic                           func,
	input  logic signed [pqu_pkg::ID_W-1:0]   new_id,
	input  logic signed [pqu_pkg::PRIO_W-1:0] new_priority,
	output logic [2:0]                     status,
	output logic signed [pqu_pkg::ID_W-1:0]   out_id,
	output logic signed [pqu_pkg::PRIO_W-1:0] out_priority,
	output logic signed [pqu_pkg::OSTAMP_W-1:0] out_stamp
);
	import pqu_pkg::*;

	// row of cells, head in cell 0
	logic [ID_W-1:0]          cell_id_q    [CAPACITY];
	logic signed [PRIO_W-1:0] cell_prio_q  [CAPACITY];
	logic [STAMP_W-1:0]       cell_stamp_q [CAPACITY];

	// neighbor values for shifting (own value at the ends)
	logic [ID_W-1:0]          shr_id    [CAPACITY];
	logic signed [PRIO_W-1:0] shr_prio  [CAPACITY];
	logic [STAMP_W-1:0]       shr_stamp [CAPACITY];
	logic [ID_W-1:0]          shl_id    [CAPACITY];
	logic signed [PRIO_W-1:0] shl_prio  [CAPACITY];
	logic [STAMP_W-1:0]       shl_stamp [CAPACITY];

	logic [CNT_W-1:0]   count_q;
	logic [STAMP_W-1:0] next_stamp_q;

	logic                     func_q;
	logic [ID_W-1:0]          id_q;
	logic signed [PRIO_W-1:0] prio_q;
	logic                     dup_q;
	logic [CAPACITY-1:0]      le_q;
	logic [CAPACITY-1:0]      le_prev;

	logic [CAPACITY-1:0] cell_valid;
	logic [CAPACITY-1:0] id_match;
	logic [CAPACITY-1:0] prio_le;

	logic full, empty, ins_ok, pop_ok;

	logic [2:0]               status_q;
	logic [ID_W-1:0]          out_id_q;
	logic [PRIO_W-1:0]        out_prio_q;
	logic [OSTAMP_W-1:0]      out_stamp_q;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_nb
			if (g == 0) begin : g_first
				assign shr_id[g]    = cell_id_q[g];
				assign shr_prio[g]  = cell_prio_q[g];
				assign shr_stamp[g] = cell_stamp_q[g];
			end else begin : g_mid_r
				assign shr_id[g]    = cell_id_q[g-1];
				assign shr_prio[g]  = cell_prio_q[g-1];
				assign shr_stamp[g] = cell_stamp_q[g-1];
			end
			if (g == CAPACITY - 1) begin : g_last
				assign shl_id[g]    = cell_id_q[g];
				assign shl_prio[g]  = cell_prio_q[g];
				assign shl_stamp[g] = cell_stamp_q[g];
			end else begin : g_mid_l
				assign shl_id[g]    = cell_id_q[g+1];
				assign shl_prio[g]  = cell_prio_q[g+1];
				assign shl_stamp[g] = cell_stamp_q[g+1];
			end
		end
	endgenerate

	// per-cell compares against the incoming item
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_valid[i] = (CNT_W'(i) < count_q);
			id_match[i]   = cell_valid[i] && (cell_id_q[i] == new_id);
			prio_le[i]    = cell_valid[i] && (cell_prio_q[i] <= new_priority);
		end
	end

	// cells holding priority <= new form a prefix; insert goes at its end
	assign le_prev = {le_q[CAPACITY-2:0], 1'b1};

	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);
	assign ins_ok = (func_q == FUNC_INSERT) && !dup_q && !full;
	assign pop_ok = (func_q == FUNC_POP) && !empty;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			id_q   <= new_id;
			prio_q <= new_priority;
			dup_q  <= |id_match;
			le_q   <= prio_le;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (ins_ok && !le_q[i]) begin
					if (le_prev[i]) begin
						cell_id_q[i]    <= id_q;
						cell_prio_q[i]  <= prio_q;
						cell_stamp_q[i] <= next_stamp_q;
					end else begin
						cell_id_q[i]    <= shr_id[i];
						cell_prio_q[i]  <= shr_prio[i];
						cell_stamp_q[i] <= shr_stamp[i];
					end
				end else if (pop_ok) begin
					cell_id_q[i]    <= shl_id[i];
					cell_prio_q[i]  <= shl_prio[i];
					cell_stamp_q[i] <= shl_stamp[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			next_stamp_q <= STAMP_W'(1);
		end else if (cmd.apply) begin
			if (ins_ok) begin
				count_q <= count_q + CNT_W'(1);
				if (next_stamp_q != STAMP_MAX) next_stamp_q <= next_stamp_q + STAMP_W'(1);
			end else if (pop_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			if (func_q == FUNC_INSERT) begin
				out_id_q    <= '1;
				out_prio_q  <= '1;
				out_stamp_q <= '1;
				priority if (dup_q) status_q <= ST_DUP;
				else if (full)      status_q <= ST_FULL;
				else                status_q <= ST_INSERTED;
			end else if (empty) begin
				status_q    <= ST_EMPTY;
				out_id_q    <= '1;
				out_prio_q  <= '1;
				out_stamp_q <= '1;
			end else begin
				status_q    <= ST_POPPED;
				out_id_q    <= cell_id_q[0];
				out_prio_q  <= cell_prio_q[0];
				out_stamp_q <= {1'b0, cell_stamp_q[0]};
			end
		end
	end

	assign status       = status_q;
	assign out_id       = out_id_q;
	assign out_priority = out_prio_q;
	assign out_stamp    = out_stamp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply && ins_ok |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted insert did not grow the queue");

	a_le_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> ((le_q & ~le_prev) == '0))
		else $error("priority compare flags are not a prefix, row out of order");

	a_stamp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_stamp_q != '0)
		else $error("next stamp wrapped to zero");
`endif

endmodule

// File: sv/priority_queue_unique_id.sv
// channel | dir | handshake     | payload
// req     | in  | valid, ready  | func, new_id, new_priority
// rsp     | out | valid, ready  | status, out_id, out_priority, out_stamp
//
// every item has an accept step and an apply step: the accept edge captures the fields
// and the parallel id and priority compares over the 16-cell row, the apply edge shifts
// the row and loads the result register
// the next item is accepted while a result still waits in the result register;
// the apply step stalls only while that register is still full
// reset clears the entry count and sets the next stamp to one; cells are not cleared
module priority_queue_unique_id (
	input  logic  clk,
	input  logic  arst_n,
	pqu_req_if.sink   req,
	pqu_rsp_if.source rsp
);
	import pqu_pkg::*;

	cmd_t cmd;

	// controller: accept, apply and result-valid sequencing
	pqu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// datapath: row of cells, compares, count, stamp and result register
	pqu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.func         (req.func),
		.new_id       (req.new_id),
		.new_priority (req.new_priority),
		.status       (rsp.status),
		.out_id       (rsp.out_id),
		.out_priority (rsp.out_priority),
		.out_stamp    (rsp.out_stamp)
	);

endmodule
